// ===== design/poly_fixed_point_root_iter_assert.svh =====
// assertion macros for the polynomial root iterator
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef POLY_FIXED_POINT_ROOT_ITER_ASSERT_SVH
`define POLY_FIXED_POINT_ROOT_ITER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PFR_ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: check failed");
`define PFR_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("%m: check failed");
`else
`define PFR_ASSERT_IMPL(label, clk, rst, prop)
`define PFR_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== design/pfr_pkg.sv =====
// shared constants and types for the polynomial root iterator
// no dependencies
`default_nettype none
package pfr_pkg;
  localparam int unsigned DefMaxDegree = 4;
  localparam int unsigned DefFracBits  = 16;
  localparam int unsigned DataW        = 32;
  localparam int unsigned CfgIdxW      = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegCoeffX4  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCoeffX3  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCoeffX2  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCoeffX1  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCoeffX0  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTol      = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMaxIter  = 3'd6;

  // multiplier handshake
  typedef struct packed {
    logic start;
    logic done;
  } mul_ctl_t;
endpackage
`default_nettype wire

// ===== design/pfr_mul.sv =====
// shift-add fixed point multiplier, one bit of the multiplier per cycle
// depends on pfr_pkg
`default_nettype none
module pfr_mul
  import pfr_pkg::*;
#(
  parameter int unsigned FRAC_BITS = DefFracBits
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    go,
  input  wire logic signed [DataW-1:0] a,
  input  wire logic signed [DataW-1:0] b,
  output logic                         done,
  output logic signed [DataW-1:0]      prod
);
  localparam int unsigned CntW = $clog2(DataW + 1);
  localparam int unsigned PW   = 2 * DataW;

  logic signed [PW-1:0] acc;
  logic signed [PW-1:0] mcand;
  logic [DataW-1:0]     mplier;
  logic [CntW-1:0]      cnt;
  logic                 busy;
  logic signed [PW-1:0] acc_next;
  logic signed [PW-1:0] shifted;

  // the top bit of b carries negative weight
  always_comb begin
    acc_next = acc;
    if (mplier[0]) begin
      if (cnt == CntW'(DataW - 1)) acc_next = acc - mcand;
      else acc_next = acc + mcand;
    end
  end

  // floor shift then saturation
  assign shifted = acc >>> FRAC_BITS;
  always_comb begin
    if (shifted > PW'(signed'(64'sh7fffffff))) prod = 32'sh7fffffff;
    else if (shifted < -PW'(signed'(64'sh80000000))) prod = 32'sh80000000;
    else prod = shifted[DataW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= '0;
        mcand  <= PW'(a);
        mplier <= b;
      end else if (busy) begin
        acc    <= acc_next;
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 1'b1;
        if (cnt == CntW'(DataW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/poly_fixed_point_root_iter.sv =====
// Polynomial root finder by fixed-point iteration x <- x - f(x), Q16.16.
// Each evaluation of f runs the Horner steps in turn and then tests the
// residual: every Horner step runs through one shared bit-serial multiplier
// that retires one multiplier bit per cycle. An item makes up to
// max_iterations+1 evaluations, so it holds busy until they are done, ending
// early when it converges, and the next start can be taken in the same cycle
// as its result. start is taken only while busy is low; the result appears for
// one cycle with out_valid and cannot be held.
`default_nettype none
module poly_fixed_point_root_iter
  import pfr_pkg::*;
#(
  parameter int unsigned MAX_DEGREE = DefMaxDegree,
  parameter int unsigned FRAC_BITS  = DefFracBits
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [CfgIdxW-1:0]      cfg_index,
  input  wire logic [DataW-1:0]        cfg_data,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic signed [DataW-1:0] start_value,
  output logic                         out_valid,
  output logic signed [DataW-1:0]      root_value,
  output logic signed [DataW-1:0]      residual,
  output logic [7:0]                   update_count,
  output logic                         converged
);
`include "poly_fixed_point_root_iter_assert.svh"

  localparam int unsigned DegW = $clog2(MAX_DEGREE + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_WAIT = 4'b0100,
    S_TEST = 4'b1000
  } state_t;

  logic signed [DataW-1:0] coef [5];
  logic [30:0]             tolerance;
  logic [7:0]              max_iterations;

  state_t                  state;
  logic signed [DataW-1:0] x;
  logic signed [DataW-1:0] acc;
  logic [DegW-1:0]         k;
  logic [7:0]              count;
  mul_ctl_t                mc;
  logic signed [DataW-1:0] prod;
  logic signed [DataW:0]   sum;
  logic signed [DataW-1:0] sum_sat;
  logic signed [DataW:0]   diff;
  logic signed [DataW-1:0] diff_sat;
  logic [DataW:0]          mag;
  logic                    below;

  // coefficient of power p; powers above four are zero
  function automatic logic signed [DataW-1:0] coef_of(input int unsigned p,
      input logic signed [DataW-1:0] c4, input logic signed [DataW-1:0] c3,
      input logic signed [DataW-1:0] c2, input logic signed [DataW-1:0] c1,
      input logic signed [DataW-1:0] c0);
    case (p)
      0: coef_of = c0;
      1: coef_of = c1;
      2: coef_of = c2;
      3: coef_of = c3;
      4: coef_of = c4;
      default: coef_of = '0;
    endcase
  endfunction

  logic signed [DataW-1:0] ck;
  logic signed [DataW-1:0] ctop;
  always_comb begin
    ck   = coef_of(32'(k) - 1, coef[0], coef[1], coef[2], coef[3], coef[4]);
    ctop = coef_of(MAX_DEGREE, coef[0], coef[1], coef[2], coef[3], coef[4]);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) coef[i] <= '0;
      tolerance      <= 31'd66;
      max_iterations <= 8'd20;
    end else if (cfg_we) begin
      case (cfg_index)
        RegCoeffX4: coef[0] <= cfg_data;
        RegCoeffX3: coef[1] <= cfg_data;
        RegCoeffX2: coef[2] <= cfg_data;
        RegCoeffX1: coef[3] <= cfg_data;
        RegCoeffX0: coef[4] <= cfg_data;
        RegTol:     tolerance <= cfg_data[30:0];
        RegMaxIter: max_iterations <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  pfr_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst(rst), .go(mc.start), .a(acc), .b(x),
    .done(mc.done), .prod(prod)
  );

  // saturated horner add and update subtract
  assign sum = {prod[DataW-1], prod} + {ck[DataW-1], ck};
  assign sum_sat = (sum[DataW] != sum[DataW-1]) ?
      {sum[DataW], {(DataW-1){~sum[DataW]}}} : sum[DataW-1:0];
  assign diff = {x[DataW-1], x} - {acc[DataW-1], acc};
  assign diff_sat = (diff[DataW] != diff[DataW-1]) ?
      {diff[DataW], {(DataW-1){~diff[DataW]}}} : diff[DataW-1:0];
  assign mag = acc[DataW-1] ? -{acc[DataW-1], acc} : {1'b0, acc};
  assign below = mag < {2'b00, tolerance};

  assign busy = (state != S_IDLE);
  assign mc.start = (state == S_MUL);

  // iteration sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state)
        S_IDLE: if (start) begin
          x     <= start_value;
          count <= '0;
          acc   <= ctop;
          k     <= DegW'(MAX_DEGREE);
          state <= S_MUL;
        end
        S_MUL: state <= S_WAIT;
        S_WAIT: if (mc.done) begin
          acc <= sum_sat;
          k   <= k - 1'b1;
          if (k == DegW'(1)) state <= S_TEST;
          else state <= S_MUL;
        end
        S_TEST: begin
          if (below || count == max_iterations) begin
            root_value   <= x;
            residual     <= acc;
            update_count <= count;
            converged    <= below;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end else begin
            x     <= diff_sat;
            count <= count + 1'b1;
            acc   <= ctop;
            k     <= DegW'(MAX_DEGREE);
            state <= S_MUL;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PFR_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `PFR_ASSERT_IMPL(a_done_in_wait, clk, rst, mc.done |-> state == S_WAIT)
  `PFR_ASSERT_IMPL(a_count_bound, clk, rst, out_valid |-> update_count <= max_iterations)
endmodule
`default_nettype wire
